[sv/groove_nearest_quantizer_unit_macros.svh]
// ----------------------------------------------------------------------------
// Groove quantizer assertion macros
// Shared assertion shorthands for the groove quantizer blocks.
// ----------------------------------------------------------------------------
`ifndef GROOVE_NEAREST_QUANTIZER_UNIT_MACROS_SVH
`define GROOVE_NEAREST_QUANTIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GNQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GNQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/gnq_pkg.sv]
// ----------------------------------------------------------------------------
// Groove quantizer package
// Sizes, codes and shared types of the groove quantizer.
// ----------------------------------------------------------------------------
package gnq_pkg;

    // Groove table geometry.
    localparam int GNQ_DEPTH   = 64;
    localparam int GNQ_ADDR_W  = (GNQ_DEPTH > 1) ? $clog2(GNQ_DEPTH) : 1;
    localparam int GNQ_CNT_W   = $clog2(GNQ_DEPTH + 1);
    localparam int GNQ_COUNT_W = 7;
    localparam int GNQ_LIM_W   = (GNQ_CNT_W > GNQ_COUNT_W) ? GNQ_CNT_W : GNQ_COUNT_W;

    // Field widths.
    localparam int GNQ_POS_W      = 32;
    localparam int GNQ_AMP_W      = 17;
    localparam int GNQ_STRENGTH_W = 17;
    localparam int GNQ_WINDOW_W   = 31;
    localparam int GNQ_INDEX_W    = 6;
    localparam int GNQ_VEL_W      = 7;
    localparam int GNQ_ENTRY_W    = 1 + GNQ_AMP_W + GNQ_POS_W;
    localparam int GNQ_CFG_IDX_W  = 8;
    localparam int GNQ_CFG_DATA_W = 32;

    // Strength is an unsigned Q1.16 factor.
    localparam int GNQ_STRENGTH_FRAC = 16;

    // Datapath widths.
    localparam int GNQ_DIST_W = GNQ_POS_W + 1;
    localparam int GNQ_MULA_W = GNQ_DIST_W + 1;
    localparam int GNQ_MULB_W = GNQ_STRENGTH_W + 1;
    localparam int GNQ_PROD_W = GNQ_MULA_W + GNQ_MULB_W;

    localparam logic [GNQ_STRENGTH_W-1:0] GNQ_STRENGTH_RESET = 17'd65536;
    localparam logic [GNQ_VEL_W-1:0]      GNQ_VEL_MAX        = 7'd127;

    // Item action codes.
    localparam logic GNQ_ACT_WRITE = 1'b0;
    localparam logic GNQ_ACT_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [GNQ_CFG_IDX_W-1:0] GNQ_REG_STRENGTH     = 8'd0;
    localparam logic [GNQ_CFG_IDX_W-1:0] GNQ_REG_GROOVE_COUNT = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_MUL_PULL,
        ST_MUL_VEL,
        ST_FINISH
    } gnq_state_t;

    // Sequencer commands to the datapath.
    typedef struct packed {
        logic start;
        logic cmp_en;
        logic mul_en;
        logic mul_vel;
        logic np_load;
        logic finish;
    } gnq_ctrl_t;

    typedef struct packed {
        logic                        matched;
        logic signed [GNQ_POS_W-1:0] new_position;
        logic [GNQ_VEL_W-1:0]        velocity;
        logic                        velocity_valid;
    } gnq_result_t;

endpackage

[sv/gnq_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module gnq_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/gnq_ctrl.sv]
// ----------------------------------------------------------------------------
// Groove quantizer sequencer
// Walks one transaction through table scan, two multiplies and result load; writes go straight to result load.
// ----------------------------------------------------------------------------
`include "groove_nearest_quantizer_unit_macros.svh"

module gnq_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_action,
    input  logic [gnq_pkg::GNQ_COUNT_W-1:0]    groove_count,
    input  logic                               out_free,
    output logic                               s_ready,
    output logic [gnq_pkg::GNQ_ADDR_W-1:0]     rd_addr,
    output gnq_pkg::gnq_ctrl_t                 ctrl
);
    import gnq_pkg::*;

    gnq_state_t             state_reg, state_next;
    logic [GNQ_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [GNQ_LIM_W-1:0]   count_ext;
    logic [GNQ_CNT_W-1:0]   limit;
    logic [GNQ_CNT_W-1:0]   cnt_inc;
    logic                   accept;

    // Counts above the table depth scan the whole table.
    assign count_ext = GNQ_LIM_W'(groove_count);
    assign limit     = (count_ext > GNQ_LIM_W'(GNQ_DEPTH)) ? GNQ_CNT_W'(GNQ_DEPTH)
                                                          : count_ext[GNQ_CNT_W-1:0];
    assign cnt_inc   = cnt_reg + GNQ_CNT_W'(1);
    assign accept    = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rd_pend_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    if (s_action == GNQ_ACT_QUERY && limit != '0) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                rd_pend_next = 1'b1;
                cnt_next     = cnt_inc;
                if (cnt_inc == limit) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:     state_next = ST_MUL_PULL;
            ST_MUL_PULL: state_next = ST_MUL_VEL;
            ST_MUL_VEL:  state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        ctrl         = '0;
        ctrl.start   = accept;
        ctrl.cmp_en  = rd_pend_reg;
        case (state_reg)
            ST_IDLE:     s_ready = 1'b1;
            ST_MUL_PULL: ctrl.mul_en = 1'b1;
            ST_MUL_VEL: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_vel = 1'b1;
                ctrl.np_load = 1'b1;
            end
            ST_FINISH:   ctrl.finish = 1'b1;
            default:     s_ready = 1'b0;
        endcase
    end

    assign rd_addr = cnt_reg[GNQ_ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    `GNQ_ASSERT_IMPL(a_scan_in_range, aclk, aresetn, state_reg == ST_SCAN, cnt_reg < limit, "scan address beyond table limit")
    `GNQ_ASSERT_IMPL(a_cmp_after_scan, aclk, aresetn, rd_pend_reg, $past(state_reg) == ST_SCAN, "compare without a scan read")
    `GNQ_ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept, state_reg != ST_IDLE, "sequencer stayed idle after a transaction")

endmodule

[sv/gnq_datapath.sv]
// ----------------------------------------------------------------------------
// Groove quantizer datapath
// Distance compare unit, shared multiplier and result arithmetic.
// ----------------------------------------------------------------------------
module gnq_datapath (
    input  logic                                  aclk,
    input  gnq_pkg::gnq_ctrl_t                    ctrl,
    input  logic signed [gnq_pkg::GNQ_POS_W-1:0]  s_note_position,
    input  logic [gnq_pkg::GNQ_WINDOW_W-1:0]      s_window,
    input  logic [gnq_pkg::GNQ_STRENGTH_W-1:0]    strength,
    input  logic [gnq_pkg::GNQ_ENTRY_W-1:0]       rd_data,
    output gnq_pkg::gnq_result_t                  result
);
    import gnq_pkg::*;

    localparam int PULL_W = GNQ_PROD_W - GNQ_STRENGTH_FRAC;
    localparam int NP_W   = PULL_W + 1;
    localparam int P_W    = GNQ_AMP_W + GNQ_STRENGTH_W;
    localparam int P255_W = P_W + 8;
    localparam int VQ_W   = P255_W - 33;

    logic signed [GNQ_POS_W-1:0]  note_reg;
    logic [GNQ_DIST_W-1:0]        min_abs_reg;
    logic signed [GNQ_DIST_W-1:0] best_dist_reg;
    logic [GNQ_AMP_W-1:0]         best_amp_reg;
    logic                         best_has_reg;
    logic                         found_reg;
    logic signed [GNQ_PROD_W-1:0] prod_reg;
    logic signed [GNQ_POS_W-1:0]  np_reg;

    logic signed [GNQ_POS_W-1:0]  ent_pos;
    logic [GNQ_AMP_W-1:0]         ent_amp;
    logic                         ent_has;
    logic signed [GNQ_DIST_W-1:0] diff;
    logic [GNQ_DIST_W-1:0]        dist_abs;
    logic                         closer;

    logic signed [GNQ_MULA_W-1:0] mul_a;
    logic signed [GNQ_MULB_W-1:0] mul_b;
    logic signed [GNQ_PROD_W-1:0] prod_biased;
    logic signed [PULL_W-1:0]     pull;
    logic signed [NP_W-1:0]       np_wide;
    logic signed [GNQ_POS_W-1:0]  np_sat;
    logic [P_W-1:0]               prod_p;
    logic [P255_W-1:0]            p255;
    logic [VQ_W-1:0]              vel_q;

    assign ent_pos = rd_data[GNQ_POS_W-1:0];
    assign ent_amp = rd_data[GNQ_POS_W +: GNQ_AMP_W];
    assign ent_has = rd_data[GNQ_ENTRY_W-1];

    // Distance compare unit: strict less-than keeps the first of equal entries.
    assign diff     = GNQ_DIST_W'(note_reg) - GNQ_DIST_W'(ent_pos);
    assign dist_abs = diff[GNQ_DIST_W-1] ? GNQ_DIST_W'(-diff) : GNQ_DIST_W'(diff);
    assign closer   = dist_abs < min_abs_reg;

    // Shared multiplier: signed pull product first, then amplitude times strength.
    assign mul_a = ctrl.mul_vel ? GNQ_MULA_W'(signed'({1'b0, best_amp_reg}))
                                : GNQ_MULA_W'(best_dist_reg);
    assign mul_b = GNQ_MULB_W'(signed'({1'b0, strength}));

    // Division by 2^16 rounding toward zero: bias negative products first.
    assign prod_biased = prod_reg[GNQ_PROD_W-1]
                         ? prod_reg + GNQ_PROD_W'((1 << GNQ_STRENGTH_FRAC) - 1)
                         : prod_reg;
    assign pull    = prod_biased[GNQ_PROD_W-1:GNQ_STRENGTH_FRAC];
    assign np_wide = NP_W'(note_reg) - NP_W'(pull);

    always_comb begin
        if (np_wide > NP_W'(signed'({1'b0, {(GNQ_POS_W-1){1'b1}}}))) begin
            np_sat = {1'b0, {(GNQ_POS_W-1){1'b1}}};
        end else if (np_wide < NP_W'(signed'({1'b1, {(GNQ_POS_W-1){1'b0}}}))) begin
            np_sat = {1'b1, {(GNQ_POS_W-1){1'b0}}};
        end else begin
            np_sat = np_wide[GNQ_POS_W-1:0];
        end
    end

    // Times 127.5 over 2^32 is times 255 over 2^33.
    assign prod_p = prod_reg[P_W-1:0];
    assign p255   = {prod_p, 8'd0} - P255_W'(prod_p);
    assign vel_q  = p255[P255_W-1:33];

    always_comb begin
        result                = '0;
        result.matched        = found_reg;
        if (found_reg) begin
            result.new_position = np_reg;
            if (best_has_reg) begin
                result.velocity_valid = 1'b1;
                result.velocity = (vel_q > VQ_W'(GNQ_VEL_MAX)) ? GNQ_VEL_MAX
                                                               : vel_q[GNQ_VEL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            note_reg    <= s_note_position;
            min_abs_reg <= GNQ_DIST_W'(s_window);
            found_reg   <= 1'b0;
        end else if (ctrl.cmp_en && closer) begin
            min_abs_reg   <= dist_abs;
            best_dist_reg <= diff;
            best_amp_reg  <= ent_amp;
            best_has_reg  <= ent_has;
            found_reg     <= 1'b1;
        end
        if (ctrl.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (ctrl.np_load) begin
            np_reg <= np_sat;
        end
    end

endmodule

[sv/groove_nearest_quantizer_unit.sv]
// ----------------------------------------------------------------------------
// Groove nearest quantizer
// Pulls a note position toward the nearest point of a groove table.
// ----------------------------------------------------------------------------
// A write transaction stores one groove point and returns an all-zero result
// through the finish state; the next transaction is taken once it is loaded.
// A query transaction scans the first min(groove_count, 64) table entries, one
// per cycle through the single read port of the groove memory, then uses one
// shared multiplier twice; its result is loaded after the scan, last-read,
// pull multiply, velocity multiply and finish states, and the next query is
// taken only after that. A query with an empty scan finishes like a write.
// Input ready is low while a transaction is in flight, and stays low longer
// while a finished result waits for the output register. The result sits in
// an output register, and a new transaction is taken while it waits. The
// table needs no clearing after reset, but every entry that a query scans must
// have been written first. Configuration writes go in only when idle and no
// input transaction is offered.
module groove_nearest_quantizer_unit (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [gnq_pkg::GNQ_CFG_IDX_W-1:0]       cfg_index,
    input  logic [gnq_pkg::GNQ_CFG_DATA_W-1:0]      cfg_data,

    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_action,
    input  logic [gnq_pkg::GNQ_INDEX_W-1:0]         s_entry_index,
    input  logic signed [gnq_pkg::GNQ_POS_W-1:0]    s_entry_position,
    input  logic [gnq_pkg::GNQ_AMP_W-1:0]           s_entry_amplitude,
    input  logic                                    s_entry_has_amplitude,
    input  logic signed [gnq_pkg::GNQ_POS_W-1:0]    s_note_position,
    input  logic [gnq_pkg::GNQ_WINDOW_W-1:0]        s_window,

    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_matched,
    output logic signed [gnq_pkg::GNQ_POS_W-1:0]    m_new_position,
    output logic [gnq_pkg::GNQ_VEL_W-1:0]           m_velocity,
    output logic                                    m_velocity_valid
);
    import gnq_pkg::*;

    logic [GNQ_STRENGTH_W-1:0] strength_reg;
    logic [GNQ_COUNT_W-1:0]    groove_count_reg;
    logic                      m_valid_reg, m_valid_next;
    gnq_result_t               res_reg;
    gnq_result_t               result;
    gnq_ctrl_t                 ctrl;
    logic [GNQ_ADDR_W-1:0]     rd_addr;
    logic [GNQ_ENTRY_W-1:0]    rd_data;
    logic [GNQ_LIM_W-1:0]      widx_ext;
    logic                      ram_we;
    logic                      out_free;
    logic                      load_out;

    // Registers change only between transactions, never during a scan.
    assign cfg_ready = s_ready && !s_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strength_reg     <= GNQ_STRENGTH_RESET;
            groove_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                GNQ_REG_STRENGTH:     strength_reg     <= cfg_data[GNQ_STRENGTH_W-1:0];
                GNQ_REG_GROOVE_COUNT: groove_count_reg <= cfg_data[GNQ_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Writes to slots beyond the table depth are dropped.
    assign widx_ext = GNQ_LIM_W'(s_entry_index);
    assign ram_we   = s_valid && s_ready && (s_action == GNQ_ACT_WRITE)
                      && (widx_ext < GNQ_LIM_W'(GNQ_DEPTH));

    gnq_ram #(
        .WIDTH (GNQ_ENTRY_W),
        .DEPTH (GNQ_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (widx_ext[GNQ_ADDR_W-1:0]),
        .wdata ({s_entry_has_amplitude, s_entry_amplitude, s_entry_position}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    gnq_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_action     (s_action),
        .groove_count (groove_count_reg),
        .out_free     (out_free),
        .s_ready      (s_ready),
        .rd_addr      (rd_addr),
        .ctrl         (ctrl)
    );

    gnq_datapath u_datapath (
        .aclk            (aclk),
        .ctrl            (ctrl),
        .s_note_position (s_note_position),
        .s_window        (s_window),
        .strength        (strength_reg),
        .rd_data         (rd_data),
        .result          (result)
    );

    // Output register: the result waits here until the sink takes it.
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = ctrl.finish && out_free;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (load_out) begin
            res_reg <= result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_matched        = res_reg.matched;
    assign m_new_position   = res_reg.new_position;
    assign m_velocity       = res_reg.velocity;
    assign m_velocity_valid = res_reg.velocity_valid;

    `GNQ_ASSERT_IMPL(a_nomatch_zero, aclk, aresetn,
        m_valid_reg && !res_reg.matched,
        res_reg.new_position == '0 && !res_reg.velocity_valid && res_reg.velocity == '0,
        "unmatched result carries data")

endmodule

[test/gnq_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Groove quantizer scoreboard
// Transaction types and a scoreboard that keeps its own copy of the groove
// table and registers, predicts each result, and checks the block's output.
// ----------------------------------------------------------------------------
package gnq_tb_pkg;

    import gnq_pkg::*;

    typedef struct {
        bit                        action;
        bit [GNQ_INDEX_W-1:0]      entry_index;
        bit signed [GNQ_POS_W-1:0] entry_position;
        bit [GNQ_AMP_W-1:0]        entry_amplitude;
        bit                        entry_has_amplitude;
        bit signed [GNQ_POS_W-1:0] note_position;
        bit [GNQ_WINDOW_W-1:0]     window;
    } groove_item_t;

    typedef struct {
        longint             position;
        bit [GNQ_AMP_W-1:0] amplitude;
        bit                 has_amplitude;
    } groove_point_t;

    class quantizer_scoreboard;
        groove_point_t           points [GNQ_DEPTH];
        bit [GNQ_STRENGTH_W-1:0] strength;
        bit [GNQ_COUNT_W-1:0]    groove_count;
        gnq_result_t             expected_results [$];
        int                      errors;

        function new();
            strength     = GNQ_STRENGTH_RESET;
            groove_count = '0;
            errors       = 0;
        endfunction

        function void set_register(logic [GNQ_CFG_IDX_W-1:0] index,
                                   logic [GNQ_CFG_DATA_W-1:0] data);
            if (index == GNQ_REG_STRENGTH) begin
                strength = data[GNQ_STRENGTH_W-1:0];
            end else if (index == GNQ_REG_GROOVE_COUNT) begin
                groove_count = data[GNQ_COUNT_W-1:0];
            end
        endfunction

        // Nearest point strictly inside the window; the first one wins a tie.
        function gnq_result_t quantize_note(groove_item_t it);
            gnq_result_t       res;
            int                scan;
            int                best;
            longint            diff;
            longint            mag;
            longint            best_dist;
            longint            min_mag;
            longint            note;
            longint            moved;
            longint unsigned   vel;
            res       = '0;
            best      = -1;
            best_dist = 0;
            note      = longint'(it.note_position);
            min_mag   = longint'(it.window);
            if (it.action == GNQ_ACT_WRITE) begin
                points[it.entry_index].position      = longint'(it.entry_position);
                points[it.entry_index].amplitude     = it.entry_amplitude;
                points[it.entry_index].has_amplitude = it.entry_has_amplitude;
                return res;
            end
            scan = (groove_count > GNQ_DEPTH) ? GNQ_DEPTH : int'(groove_count);
            for (int i = 0; i < scan; i++) begin
                diff = note - points[i].position;
                mag  = (diff < 0) ? -diff : diff;
                if (mag < min_mag) begin
                    min_mag   = mag;
                    best_dist = diff;
                    best      = i;
                end
            end
            if (best < 0) begin
                return res;
            end
            // Signed division truncates toward zero, as the pull must.
            moved = note - (best_dist * longint'(strength)) / 65536;
            if (moved > 64'sd2147483647) begin
                moved = 64'sd2147483647;
            end else if (moved < -64'sd2147483648) begin
                moved = -64'sd2147483648;
            end
            res.matched      = 1'b1;
            res.new_position = moved[GNQ_POS_W-1:0];
            if (points[best].has_amplitude) begin
                vel = (longint'(points[best].amplitude) * longint'(strength) * 255) >> 33;
                res.velocity       = (vel > 127) ? GNQ_VEL_MAX : vel[GNQ_VEL_W-1:0];
                res.velocity_valid = 1'b1;
            end
            return res;
        endfunction

        function void note_input(groove_item_t it);
            expected_results.insert(expected_results.size(), quantize_note(it));
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(gnq_result_t got);
            gnq_result_t want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction, expected none, actual %0h",
                         $time, got);
                return;
            end
            want = expected_results.pop_front();
            compare_field("matched", want.matched, got.matched);
            compare_field("new_position", want.new_position, got.new_position);
            compare_field("velocity", want.velocity, got.velocity);
            compare_field("velocity_valid", want.velocity_valid, got.velocity_valid);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

[test/groove_nearest_quantizer_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Groove nearest quantizer testbench
// Drives table writes and note queries through the valid/ready channels with
// random gaps and stalls, reprograms strength and scan count between phases,
// and checks every result against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module groove_nearest_quantizer_unit_tb;

    import gnq_pkg::*;
    import gnq_tb_pkg::*;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int MAX_GAP         = 6;
    localparam int LONG_HOLD       = 400;
    localparam int HOLD_AT_RESULT  = 150;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 80;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [GNQ_CFG_IDX_W-1:0]   cfg_index;
    logic [GNQ_CFG_DATA_W-1:0]  cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_action;
    logic [GNQ_INDEX_W-1:0]     s_entry_index;
    logic signed [GNQ_POS_W-1:0] s_entry_position;
    logic [GNQ_AMP_W-1:0]       s_entry_amplitude;
    logic                       s_entry_has_amplitude;
    logic signed [GNQ_POS_W-1:0] s_note_position;
    logic [GNQ_WINDOW_W-1:0]    s_window;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_matched;
    logic signed [GNQ_POS_W-1:0] m_new_position;
    logic [GNQ_VEL_W-1:0]       m_velocity;
    logic                       m_velocity_valid;

    quantizer_scoreboard         quant_sb;
    bit                          idle_on = 1'b1;
    int                          results_seen = 0;
    int                          quiet_cycles = 0;
    bit                          slot_written [GNQ_DEPTH];
    logic signed [GNQ_POS_W-1:0] slot_position [GNQ_DEPTH];

    groove_nearest_quantizer_unit DUT (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_action              (s_action),
        .s_entry_index         (s_entry_index),
        .s_entry_position      (s_entry_position),
        .s_entry_amplitude     (s_entry_amplitude),
        .s_entry_has_amplitude (s_entry_has_amplitude),
        .s_note_position       (s_note_position),
        .s_window              (s_window),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_matched             (m_matched),
        .m_new_position        (m_new_position),
        .m_velocity            (m_velocity),
        .m_velocity_valid      (m_velocity_valid)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic int draw_gap();
        return idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
    endfunction

    function automatic groove_item_t entry_item(bit [GNQ_INDEX_W-1:0] slot,
                                                bit signed [GNQ_POS_W-1:0] pos,
                                                bit [GNQ_AMP_W-1:0] amp, bit has_amp);
        groove_item_t it;
        it.action              = GNQ_ACT_WRITE;
        it.entry_index         = slot;
        it.entry_position      = pos;
        it.entry_amplitude     = amp;
        it.entry_has_amplitude = has_amp;
        it.note_position       = $urandom;
        it.window              = 31'($urandom);
        return it;
    endfunction

    function automatic groove_item_t query_item(bit signed [GNQ_POS_W-1:0] note,
                                                bit [GNQ_WINDOW_W-1:0] win);
        groove_item_t it;
        it                 = entry_item(6'($urandom), $urandom, 17'($urandom),
                                        1'($urandom));
        it.action          = GNQ_ACT_QUERY;
        it.note_position   = note;
        it.window          = win;
        return it;
    endfunction

    // Queries only go out once every slot they scan holds a written point;
    // until then the missing slots are filled first.
    function automatic groove_item_t random_item();
        groove_item_t it;
        int           scan;
        int           hole;
        int           pick;
        scan = (quant_sb.groove_count > GNQ_DEPTH) ? GNQ_DEPTH : int'(quant_sb.groove_count);
        hole = -1;
        for (int i = scan - 1; i >= 0; i--) begin
            if (!slot_written[i]) hole = i;
        end
        it = entry_item(6'($urandom),
                        ($urandom_range(0, 3) == 0) ? 32'($urandom)
                            : 32'($urandom_range(0, 2097152)) - 32'd1048576,
                        ($urandom_range(0, 3) == 0) ? 17'($urandom)
                            : 17'($urandom_range(0, 65536)),
                        1'($urandom));
        if (hole >= 0) begin
            it.entry_index = 6'(hole);
        end else if ($urandom_range(0, 99) >= 30) begin
            it.action = GNQ_ACT_QUERY;
            if (scan > 0 && $urandom_range(0, 99) < 75) begin
                pick = int'($urandom_range(0, scan - 1));
                it.note_position = slot_position[pick] + 32'($urandom_range(0, 131072))
                                   - 32'd65536;
            end
            case ($urandom_range(0, 9))
                0:       it.window = '0;
                1:       it.window = '1;
                2, 3, 4: it.window = 31'($urandom_range(0, 65536));
                5, 6:    it.window = 31'($urandom_range(0, 1048576));
                default: it.window = 31'($urandom);
            endcase
        end
        return it;
    endfunction

    task automatic send_item(input groove_item_t it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_action              <= it.action;
        s_entry_index         <= it.entry_index;
        s_entry_position      <= it.entry_position;
        s_entry_amplitude     <= it.entry_amplitude;
        s_entry_has_amplitude <= it.entry_has_amplitude;
        s_note_position       <= it.note_position;
        s_window              <= it.window;
        s_valid               <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        quant_sb.note_input(it);
        if (it.action == GNQ_ACT_WRITE) begin
            slot_written[it.entry_index]  = 1'b1;
            slot_position[it.entry_index] = it.entry_position;
        end
    endtask

    // Stop offering transactions and wait until every result is back.
    task automatic settle_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (quant_sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [GNQ_CFG_IDX_W-1:0] index,
                                  input logic [GNQ_CFG_DATA_W-1:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        quant_sb.set_register(index, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_directed();
        // An empty scan right after reset finds nothing.
        send_item(query_item(32'sd0, 31'h7FFFFFFF));
        send_item(entry_item(6'd0, 32'sd0, 17'd65536, 1'b1));
        send_item(entry_item(6'd1, 32'h7FFFFFFF, 17'd0, 1'b1));
        send_item(entry_item(6'd2, 32'h80000000, 17'h1FFFF, 1'b0));
        send_item(entry_item(6'd3, 32'sd0, 17'd1, 1'b1));
        send_item(entry_item(6'd63, 32'h12345678, 17'd40000, 1'b1));
        settle_block();
        write_register(GNQ_REG_GROOVE_COUNT, 32'd4);
        // Slots 0 and 3 tie at zero distance; slot 0 must win.
        send_item(query_item(32'sd0, 31'd1));
        send_item(query_item(32'sd0, 31'd0));
        send_item(query_item(32'h7FFFFFFF, 31'h7FFFFFFF));
        send_item(query_item(32'h80000000, 31'd1));
        send_item(query_item(32'sh8000, 31'h10000));
        // A distance equal to the window is outside it.
        send_item(query_item(32'sd5, 31'd5));
        settle_block();
        write_register(GNQ_REG_STRENGTH, 32'h0001FFFF);
        write_register(GNQ_REG_GROOVE_COUNT, 32'd3);
        write_register(8'hFF, 32'hFFFFFFFF);
        write_register(8'd2, 32'd0);
        // Overshooting strength drives the position past both rails.
        send_item(query_item(32'h40000000, 31'h7FFFFFFF));
        send_item(query_item(32'hBFFFFFFF, 31'h7FFFFFFF));
        send_item(query_item(32'sh100, 31'h7FFFFFFF));
        settle_block();
        write_register(GNQ_REG_STRENGTH, 32'd0);
        write_register(GNQ_REG_GROOVE_COUNT, 32'd4);
        send_item(query_item(32'sh1234, 31'h7FFFFFFF));
        settle_block();
        write_register(GNQ_REG_STRENGTH, 32'd32768);
        // Half pull of an odd distance truncates toward zero on both sides.
        send_item(query_item(32'sd3, 31'h7FFFFFFF));
        send_item(query_item(-32'sd3, 31'h7FFFFFFF));
    endtask

    task automatic run_random_phase(input int phase);
        logic [GNQ_STRENGTH_W-1:0] pull;
        logic [GNQ_COUNT_W-1:0]    count;
        settle_block();
        case (phase)
            0: begin pull = GNQ_STRENGTH_RESET; count = 7'd64;  end
            1: begin pull = 17'h1FFFF;          count = 7'd127; end
            2: begin pull = 17'd0;              count = 7'd1;   end
            3: begin pull = 17'd32768;          count = 7'd65;  end
            4: begin pull = 17'd1;              count = 7'd2;   end
            default: begin
                pull  = ($urandom_range(0, 1) == 0) ? 17'($urandom)
                                                    : 17'($urandom_range(0, 65536));
                count = 7'($urandom_range(0, 127));
            end
        endcase
        idle_on = (phase % 3) != 2;
        write_register(GNQ_REG_STRENGTH, {15'($urandom), pull});
        write_register(GNQ_REG_GROOVE_COUNT, {25'($urandom), count});
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 3 && n == 40) settle_block();
            send_item(random_item());
        end
    endtask

    initial begin
        quant_sb              = new();
        aresetn               = 1'b0;
        cfg_valid             = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        s_valid               = 1'b0;
        s_action              = GNQ_ACT_WRITE;
        s_entry_index         = '0;
        s_entry_position      = '0;
        s_entry_amplitude     = '0;
        s_entry_has_amplitude = 1'b0;
        s_note_position       = '0;
        s_window              = '0;
        foreach (slot_written[i]) slot_written[i] = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            run_random_phase(phase);
        end
        settle_block();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (quant_sb.errors == 0 && quant_sb.pending() == 0) begin
            $display("groove_nearest_quantizer_unit_tb passed");
        end else begin
            $display("groove_nearest_quantizer_unit_tb failed");
        end
        $finish;
    end

    // Result side: takes each transaction, then stalls for a drawn number of
    // cycles; once in the run it holds off long enough to back up the input.
    initial begin
        int          stall;
        gnq_result_t got;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = {m_matched, m_new_position, m_velocity, m_velocity_valid};
                quant_sb.check_result(got);
                results_seen++;
                stall = (results_seen == HOLD_AT_RESULT) ? LONG_HOLD : draw_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("groove_nearest_quantizer_unit_tb failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule

[filelist.f]
+incdir+sv
sv/gnq_pkg.sv
sv/gnq_ram.sv
sv/gnq_ctrl.sv
sv/gnq_datapath.sv
sv/groove_nearest_quantizer_unit.sv
test/gnq_tb_pkg.sv
test/groove_nearest_quantizer_unit_tb.sv
